// ===== rtl/core/mpool_pkg.sv =====
// Shared types and constants for the streaming 2-D max-pool block.
package mpool_pkg;

    localparam int POOL_REG_W  = 4;
    localparam int PLANE_REG_W = 11;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_INDEX_W = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_POOL_SIZE    = 2'd0,
        REG_STRIDE       = 2'd1,
        REG_PLANE_WIDTH  = 2'd2,
        REG_PLANE_HEIGHT = 2'd3
    } cfg_reg_t;

    localparam logic [POOL_REG_W-1:0]  POOL_SIZE_RST    = 4'd2;
    localparam logic [POOL_REG_W-1:0]  STRIDE_RST       = 4'd2;
    localparam logic [PLANE_REG_W-1:0] PLANE_WIDTH_RST  = 11'd28;
    localparam logic [PLANE_REG_W-1:0] PLANE_HEIGHT_RST = 11'd28;

endpackage

// ===== rtl/core/max_pool_2d_stream_top.sv =====
// Streaming 2-D max pooling over raster-order feature-map planes.
//
// Usage:
//   sample channel: one signed fixed-point word per handshake, raster order,
//     plane after plane. A word is taken when sample_valid and sample_ready
//     are both high.
//   result channel: one word per completed pool window, pooled_value plus
//     last_of_plane on the final window of a plane.
//   cfg channel: cfg_index selects pool_size, stride, plane_width or
//     plane_height; cfg_ready is always high. Write only while the block is
//     drained.
// Timing:
//   One sample per cycle sustained unless an extent recompute runs or a held
//   result stalls the compare stage; a result passes compare then output regs.
//   The running maxima live in one memory of MAX_WIDTH words, read when a
//   sample is taken, written as compare advances; forwarding covers column hits.
// Reset and configuration:
//   After reset and after every configuration write, a bit-serial remainder
//   unit derives the usable plane extent from width, height and stride;
//   sample_ready stays low while it runs. Position counters clear at reset.
// Stalls:
//   A held result stays in the output register; the block keeps taking
//   samples until a second result would need that register.
module max_pool_2d_stream_top #(
    parameter int MAX_WIDTH   = 1024,
    parameter int SAMPLE_BITS = 16,
    parameter int MAX_POOL    = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  mpool_pkg::cfg_reg_t                  cfg_index,
    input  logic [mpool_pkg::CFG_DATA_W-1:0]     cfg_data,
    // sample stream
    input  logic                                 sample_valid,
    output logic                                 sample_ready,
    input  logic signed [SAMPLE_BITS-1:0]        sample,
    // result stream
    output logic                                 result_valid,
    input  logic                                 result_ready,
    output logic signed [SAMPLE_BITS-1:0]        pooled_value,
    output logic                                 last_of_plane
);
    import mpool_pkg::*;

    // widths
    localparam int CW   = $clog2(MAX_WIDTH + 1);    // plane counters, limits
    localparam int AW   = $clog2(MAX_WIDTH);        // memory address
    localparam int PW   = $clog2(MAX_POOL + 1);     // pool size, stride, phases
    localparam int RW   = PW + 1;                   // remainder trial
    localparam int DCW  = $clog2(CW + 1);           // remainder step counter
    localparam int DIW  = $clog2(CW);               // bit index into plane size
    localparam int WCMP = (CW > PLANE_REG_W) ? CW : PLANE_REG_W;
    localparam int PCMP = (PW > POOL_REG_W) ? PW : POOL_REG_W;

    // configuration registers
    logic [POOL_REG_W-1:0]  pool_size_reg;
    logic [POOL_REG_W-1:0]  stride_reg;
    logic [PLANE_REG_W-1:0] plane_width_reg;
    logic [PLANE_REG_W-1:0] plane_height_reg;
    logic                   cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid & cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_size_reg    <= POOL_SIZE_RST;
            stride_reg       <= STRIDE_RST;
            plane_width_reg  <= PLANE_WIDTH_RST;
            plane_height_reg <= PLANE_HEIGHT_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_POOL_SIZE:    pool_size_reg    <= cfg_data[POOL_REG_W-1:0];
                REG_STRIDE:       stride_reg       <= cfg_data[POOL_REG_W-1:0];
                REG_PLANE_WIDTH:  plane_width_reg  <= cfg_data[PLANE_REG_W-1:0];
                REG_PLANE_HEIGHT: plane_height_reg <= cfg_data[PLANE_REG_W-1:0];
                default:          ;
            endcase
        end
    end

    // effective window size, stride and plane extent (clamped)
    logic [PCMP-1:0] p_cmp;
    logic [PCMP-1:0] s_cmp;
    logic [PW-1:0]   p_eff;
    logic [PW-1:0]   s_eff;
    logic [WCMP-1:0] w_cmp;
    logic [WCMP-1:0] h_cmp;
    logic [CW-1:0]   w_eff;
    logic [CW-1:0]   h_eff;

    assign p_cmp = PCMP'(pool_size_reg);
    assign s_cmp = PCMP'(stride_reg);
    assign p_eff = (p_cmp == '0) ? PW'(1) :
                   (p_cmp > PCMP'(MAX_POOL)) ? PW'(MAX_POOL) : PW'(p_cmp);
    assign s_eff = (s_cmp < PCMP'(p_eff)) ? p_eff :
                   (s_cmp > PCMP'(MAX_POOL)) ? PW'(MAX_POOL) : PW'(s_cmp);

    assign w_cmp = WCMP'(plane_width_reg);
    assign h_cmp = WCMP'(plane_height_reg);
    assign w_eff = (w_cmp == '0) ? CW'(1) :
                   (w_cmp > WCMP'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(w_cmp);
    assign h_eff = (h_cmp == '0) ? CW'(1) :
                   (h_cmp > WCMP'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(h_cmp);

    // bit-serial remainders of width and height by stride, quotient of width
    logic [DCW-1:0] div_cnt_reg;
    logic [PW-1:0]  rem_w_reg;
    logic [PW-1:0]  rem_h_reg;
    logic [CW-1:0]  quo_w_reg;
    logic           div_busy;
    logic [DCW-1:0] div_step;
    logic [DIW-1:0] div_bit_idx;
    logic [RW-1:0]  trial_w;
    logic [RW-1:0]  trial_h;
    logic           ge_w;
    logic           ge_h;

    assign div_busy    = (div_cnt_reg != '0);
    assign div_step    = div_cnt_reg - 1'b1;
    assign div_bit_idx = div_step[DIW-1:0];
    assign trial_w     = {rem_w_reg, w_eff[div_bit_idx]};
    assign trial_h     = {rem_h_reg, h_eff[div_bit_idx]};
    assign ge_w        = (trial_w >= RW'(s_eff));
    assign ge_h        = (trial_h >= RW'(s_eff));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= DCW'(CW);
            rem_w_reg   <= '0;
            rem_h_reg   <= '0;
            quo_w_reg   <= '0;
        end
        else if (cfg_write)
        begin
            div_cnt_reg <= DCW'(CW);
            rem_w_reg   <= '0;
            rem_h_reg   <= '0;
            quo_w_reg   <= '0;
        end
        else if (div_busy)
        begin
            div_cnt_reg <= div_step;
            rem_w_reg   <= ge_w ? PW'(trial_w - RW'(s_eff)) : PW'(trial_w);
            rem_h_reg   <= ge_h ? PW'(trial_h - RW'(s_eff)) : PW'(trial_h);
            quo_w_reg   <= {quo_w_reg[CW-2:0], ge_w};
        end
    end

    // usable extent: largest multiple of stride within the plane
    logic [CW-1:0] col_lim;
    logic [CW-1:0] row_lim;

    assign col_lim = w_eff - CW'(rem_w_reg);
    assign row_lim = h_eff - CW'(rem_h_reg);

    // position in the plane
    logic [CW-1:0] col_count_reg;
    logic [CW-1:0] row_count_reg;
    logic [PW-1:0] col_phase_reg;
    logic [PW-1:0] row_phase_reg;
    logic [AW-1:0] window_column_reg;

    logic sample_take;
    logic col_wrap;
    logic row_wrap;
    logic col_phase_wrap;
    logic row_phase_wrap;
    logic in_range;
    logic in_window;
    logic first_of_window;
    logic close_window;
    logic last_col;
    logic last_row;

    assign col_wrap       = ({1'b0, col_count_reg} + 1'b1) >= {1'b0, w_eff};
    assign row_wrap       = ({1'b0, row_count_reg} + 1'b1) >= {1'b0, h_eff};
    assign col_phase_wrap = ({1'b0, col_phase_reg} + 1'b1) >= {1'b0, s_eff};
    assign row_phase_wrap = ({1'b0, row_phase_reg} + 1'b1) >= {1'b0, s_eff};

    assign in_range        = (col_count_reg < col_lim) && (row_count_reg < row_lim);
    assign in_window       = (row_phase_reg < p_eff) && (col_phase_reg < p_eff);
    assign first_of_window = (row_phase_reg == '0) && (col_phase_reg == '0);
    assign close_window    = (row_phase_reg == p_eff - 1'b1) &&
                             (col_phase_reg == p_eff - 1'b1);
    assign last_col = ((CW+1)'(window_column_reg) + 1'b1) == (CW+1)'(quo_w_reg);
    // row band is the last one when one more stride reaches the limit
    assign last_row = ({1'b0, row_count_reg} + (CW+1)'(s_eff)) >= {1'b0, row_lim};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg     <= '0;
            row_count_reg     <= '0;
            col_phase_reg     <= '0;
            row_phase_reg     <= '0;
            window_column_reg <= '0;
        end
        else if (sample_take)
        begin
            if (col_wrap)
            begin
                col_count_reg     <= '0;
                col_phase_reg     <= '0;
                window_column_reg <= '0;
                if (row_wrap)
                begin
                    row_count_reg <= '0;
                    row_phase_reg <= '0;
                end
                else
                begin
                    row_count_reg <= row_count_reg + 1'b1;
                    row_phase_reg <= row_phase_wrap ? '0 : row_phase_reg + 1'b1;
                end
            end
            else
            begin
                col_count_reg <= col_count_reg + 1'b1;
                if (col_phase_wrap)
                begin
                    col_phase_reg     <= '0;
                    window_column_reg <= window_column_reg + 1'b1;
                end
                else
                begin
                    col_phase_reg <= col_phase_reg + 1'b1;
                end
            end
        end
    end

    // compare stage: sample, read data and window flags
    logic                          s1_valid_reg;
    logic signed [SAMPLE_BITS-1:0] s1_sample_reg;
    logic [AW-1:0]                 s1_addr_reg;
    logic                          s1_upd_reg;
    logic                          s1_first_reg;
    logic                          s1_emit_reg;
    logic                          s1_last_reg;
    logic                          fwd_reg;
    logic signed [SAMPLE_BITS-1:0] fwd_data_reg;
    logic signed [SAMPLE_BITS-1:0] rd_data_reg;
    logic signed [SAMPLE_BITS-1:0] partial_max_mem [MAX_WIDTH];

    logic                          s1_adv;
    logic                          mem_we;
    logic signed [SAMPLE_BITS-1:0] prev_max;
    logic signed [SAMPLE_BITS-1:0] new_max;

    logic                          result_valid_reg;
    logic signed [SAMPLE_BITS-1:0] pooled_value_reg;
    logic                          last_of_plane_reg;
    logic                          result_load;

    assign s1_adv       = s1_valid_reg &
                          (~s1_emit_reg | ~result_valid_reg | result_ready);
    assign sample_ready = ~div_busy & (~s1_valid_reg | s1_adv);
    assign sample_take  = sample_valid & sample_ready;
    assign mem_we       = s1_adv & s1_upd_reg;
    assign result_load  = s1_adv & s1_emit_reg;

    // previous word may have written this column at the read edge
    assign prev_max = fwd_reg ? fwd_data_reg : rd_data_reg;
    assign new_max  = (s1_first_reg || (s1_sample_reg > prev_max)) ?
                      s1_sample_reg : prev_max;

    always_ff @(posedge clk)
    begin
        if (sample_take)
        begin
            rd_data_reg <= partial_max_mem[window_column_reg];
        end
        if (mem_we)
        begin
            partial_max_mem[s1_addr_reg] <= new_max;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_take)
        begin
            s1_sample_reg <= sample;
            s1_addr_reg   <= window_column_reg;
            s1_first_reg  <= first_of_window;
            s1_last_reg   <= last_col & last_row;
            fwd_reg       <= mem_we && (s1_addr_reg == window_column_reg);
            fwd_data_reg  <= new_max;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_upd_reg   <= 1'b0;
            s1_emit_reg  <= 1'b0;
        end
        else if (sample_take)
        begin
            s1_valid_reg <= 1'b1;
            s1_upd_reg   <= in_range & in_window;
            s1_emit_reg  <= in_range & in_window & close_window;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (result_load)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_load)
        begin
            pooled_value_reg  <= new_max;
            last_of_plane_reg <= s1_last_reg;
        end
    end

    assign result_valid  = result_valid_reg;
    assign pooled_value  = pooled_value_reg;
    assign last_of_plane = last_of_plane_reg;

    // checks
    a_cfg_blocks_samples: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |=> !sample_ready)
        else $error("sample taken while extent recompute pending");

    a_emit_needs_update: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_emit_reg |-> s1_upd_reg)
        else $error("window closes without a maximum update");

    a_result_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(result_load))
        else $error("result appeared without a closing window");

    a_rem_below_stride: assert property (@(posedge clk) disable iff (!rst_n)
        !div_busy |-> (rem_w_reg < s_eff) && (rem_h_reg < s_eff))
        else $error("plane remainder not below stride");

endmodule
